/* rtl/tsbm_pkg.sv */
// Package: shared types, phase codes and register indices for the sensor bus master.
`timescale 1ns / 1ps

package tsbm_pkg;

  // Operation codes (also the request codes on cmd)
  localparam logic [2:0] OP_IDLE   = 3'd0;
  localparam logic [2:0] OP_RESET  = 3'd1;
  localparam logic [2:0] OP_STATUS = 3'd2;
  localparam logic [2:0] OP_TEMP   = 3'd3;
  localparam logic [2:0] OP_HUMI   = 3'd4;

  // Sequencer phase codes
  localparam logic [4:0] PH_RST_HI = 5'd0;
  localparam logic [4:0] PH_RST_LO = 5'd1;
  localparam logic [4:0] PH_S1     = 5'd2;
  localparam logic [4:0] PH_S2     = 5'd3;
  localparam logic [4:0] PH_S3     = 5'd4;
  localparam logic [4:0] PH_S4     = 5'd5;
  localparam logic [4:0] PH_S5     = 5'd6;
  localparam logic [4:0] PH_W_LO   = 5'd7;
  localparam logic [4:0] PH_W_DAT  = 5'd8;
  localparam logic [4:0] PH_W_HI   = 5'd9;
  localparam logic [4:0] PH_W_T0   = 5'd10;
  localparam logic [4:0] PH_W_T1   = 5'd11;
  localparam logic [4:0] PH_W_T2   = 5'd12;
  localparam logic [4:0] PH_W_T3   = 5'd13;
  localparam logic [4:0] PH_W_T4   = 5'd14;
  localparam logic [4:0] PH_POLL   = 5'd15;
  localparam logic [4:0] PH_R_REL  = 5'd16;
  localparam logic [4:0] PH_R_HI   = 5'd17;
  localparam logic [4:0] PH_R_SMP  = 5'd18;
  localparam logic [4:0] PH_R_LO   = 5'd19;
  localparam logic [4:0] PH_R_ACK  = 5'd20;
  localparam logic [4:0] PH_R_AHI  = 5'd21;
  localparam logic [4:0] PH_R_ALO  = 5'd22;
  localparam logic [4:0] PH_R_END  = 5'd23;

  // Bus sequence lengths
  localparam logic [3:0] RESET_PULSES = 4'd9;
  localparam logic [3:0] BYTE_BITS    = 4'd8;

  // Configuration register indices
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CMD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_VAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CMD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMI_CMD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 3'd4;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic [7:0]  RST_STATUS_CMD = 8'd6;
  localparam logic [7:0]  RST_STATUS_VAL = 8'd0;
  localparam logic [7:0]  RST_TEMP_CMD   = 8'd3;
  localparam logic [7:0]  RST_HUMI_CMD   = 8'd5;
  localparam logic [23:0] RST_WAIT_LIMIT = 24'd50000;

  typedef struct packed {
    logic [7:0]  status_write_command;
    logic [7:0]  status_value;
    logic [7:0]  temperature_command;
    logic [7:0]  humidity_command;
    logic [23:0] wait_limit;
  } cfg_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] raw_value;
  } result_t;

endpackage

/* rtl/tsbm_if.sv */
// Interfaces: tick item channel and result item channel.
`timescale 1ns / 1ps

interface tsbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       data_line;

  modport source (output valid, output cmd, output data_line, input ready);
  modport sink   (input valid, input cmd, input data_line, output ready);
endinterface

interface tsbm_out_if;
  logic        valid;
  logic        ready;
  logic        clock_level;
  logic        data_release;
  logic        busy_res;
  logic        done_res;
  logic        timed_out;
  logic [15:0] raw_value;

  modport source (output valid, output clock_level, output data_release, output busy_res,
                  output done_res, output timed_out, output raw_value, input ready);
  modport sink   (input valid, input clock_level, input data_release, input busy_res,
                  input done_res, input timed_out, input raw_value, output ready);
endinterface

/* rtl/tsbm_cfg.sv */
// Configuration register bank written through the plain write port.
`timescale 1ns / 1ps

module tsbm_cfg
  import tsbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Index decode; writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_STATUS_CMD: cfg_nxt.status_write_command = wr_data[7:0];
        CFG_STATUS_VAL: cfg_nxt.status_value         = wr_data[7:0];
        CFG_TEMP_CMD:   cfg_nxt.temperature_command  = wr_data[7:0];
        CFG_HUMI_CMD:   cfg_nxt.humidity_command     = wr_data[7:0];
        CFG_WAIT_LIMIT: cfg_nxt.wait_limit           = wr_data[23:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_write_command <= RST_STATUS_CMD;
      cfg_r.status_value         <= RST_STATUS_VAL;
      cfg_r.temperature_command  <= RST_TEMP_CMD;
      cfg_r.humidity_command     <= RST_HUMI_CMD;
      cfg_r.wait_limit           <= RST_WAIT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/tsbm_seq.sv */
// Bus sequencer: pin state, phase machine and next result for each tick item.
`timescale 1ns / 1ps

module tsbm_seq
  import tsbm_pkg::*;
#(
  parameter int unsigned WAIT_COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [2:0] cmd,
  input  logic       line,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [2:0]                 op_r, op_nxt;
  logic [4:0]                 phase_r, phase_nxt;
  logic [3:0]                 bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic [15:0]                word_r, word_nxt;
  logic [1:0]                 byte_idx_r, byte_idx_nxt;
  logic                       clk_r, clk_nxt;
  logic                       dat_r, dat_nxt;
  logic [WAIT_COUNT_BITS-1:0] wait_cnt_r, wait_cnt_nxt;

  logic        fin_done, fin_timeout;
  logic [15:0] fin_raw;
  logic [3:0]  bit_inc;
  logic        wait_expired;

  assign bit_inc      = bit_cnt_r + 4'd1;
  assign wait_expired = (32'(wait_cnt_r) >= 32'(cfg.wait_limit)) || (&wait_cnt_r);

  // Next state for one tick
  always_comb begin
    op_nxt       = op_r;
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    word_nxt     = word_r;
    byte_idx_nxt = byte_idx_r;
    clk_nxt      = clk_r;
    dat_nxt      = dat_r;
    wait_cnt_nxt = wait_cnt_r;
    fin_done     = 1'b0;
    fin_timeout  = 1'b0;
    fin_raw      = 16'd0;

    if (op_r == OP_IDLE) begin
      // Request tick also does the first pin step
      if (cmd == OP_RESET) begin
        op_nxt      = OP_RESET;
        dat_nxt     = 1'b1;
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_RST_HI;
      end else if (cmd == OP_STATUS || cmd == OP_TEMP || cmd == OP_HUMI) begin
        op_nxt    = cmd;
        clk_nxt   = 1'b1;
        phase_nxt = PH_S1;
      end
    end else begin
      unique case (phase_r)
        PH_RST_HI: begin
          clk_nxt   = 1'b1;
          phase_nxt = PH_RST_LO;
        end
        PH_RST_LO: begin
          clk_nxt     = 1'b0;
          bit_cnt_nxt = bit_inc;
          if (bit_inc >= RESET_PULSES) begin
            op_nxt    = OP_IDLE;
            phase_nxt = PH_RST_HI;
            fin_done  = 1'b1;
          end else begin
            phase_nxt = PH_RST_HI;
          end
        end
        PH_S1: begin
          dat_nxt   = 1'b0;
          phase_nxt = PH_S2;
        end
        PH_S2: begin
          clk_nxt   = 1'b0;
          phase_nxt = PH_S3;
        end
        PH_S3: begin
          clk_nxt   = 1'b1;
          phase_nxt = PH_S4;
        end
        PH_S4: begin
          dat_nxt   = 1'b1;
          phase_nxt = PH_S5;
        end
        PH_S5: begin
          clk_nxt      = 1'b0;
          byte_idx_nxt = 2'd0;
          bit_cnt_nxt  = 4'd0;
          phase_nxt    = PH_W_LO;
          if (op_r == OP_STATUS) begin
            shift_nxt = cfg.status_write_command;
          end else if (op_r == OP_TEMP) begin
            shift_nxt = cfg.temperature_command;
          end else begin
            shift_nxt = cfg.humidity_command;
          end
        end
        PH_W_LO: begin
          clk_nxt   = 1'b0;
          phase_nxt = PH_W_DAT;
        end
        PH_W_DAT: begin
          dat_nxt   = shift_r[7];
          phase_nxt = PH_W_HI;
        end
        PH_W_HI: begin
          clk_nxt     = 1'b1;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= BYTE_BITS) ? PH_W_T0 : PH_W_LO;
        end
        PH_W_T0: begin
          clk_nxt   = 1'b0;
          phase_nxt = PH_W_T1;
        end
        PH_W_T1: begin
          dat_nxt   = 1'b1;
          phase_nxt = PH_W_T2;
        end
        PH_W_T2: begin
          clk_nxt   = 1'b1;
          phase_nxt = PH_W_T3;
        end
        PH_W_T3: begin
          clk_nxt   = 1'b0;
          phase_nxt = PH_W_T4;
        end
        PH_W_T4: begin
          // Write acknowledge is clocked but not checked
          dat_nxt = 1'b1;
          if (op_r == OP_STATUS) begin
            if (byte_idx_r == 2'd0) begin
              byte_idx_nxt = 2'd1;
              shift_nxt    = cfg.status_value;
              bit_cnt_nxt  = 4'd0;
              phase_nxt    = PH_W_LO;
            end else begin
              op_nxt    = OP_IDLE;
              phase_nxt = PH_RST_HI;
              fin_done  = 1'b1;
            end
          end else begin
            wait_cnt_nxt = '0;
            phase_nxt    = PH_POLL;
          end
        end
        PH_POLL: begin
          // Sensor pulls data low when the conversion is ready
          if (!line) begin
            byte_idx_nxt = 2'd0;
            bit_cnt_nxt  = 4'd0;
            phase_nxt    = PH_R_REL;
          end else if (wait_expired) begin
            word_nxt    = 16'd0;
            op_nxt      = OP_IDLE;
            phase_nxt   = PH_RST_HI;
            fin_done    = 1'b1;
            fin_timeout = 1'b1;
          end else begin
            wait_cnt_nxt = wait_cnt_r + 1'b1;
          end
        end
        PH_R_REL: begin
          dat_nxt     = 1'b1;
          shift_nxt   = 8'd0;
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_R_HI;
        end
        PH_R_HI: begin
          clk_nxt   = 1'b1;
          phase_nxt = PH_R_SMP;
        end
        PH_R_SMP: begin
          shift_nxt   = {shift_r[6:0], line};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = PH_R_LO;
        end
        PH_R_LO: begin
          clk_nxt   = 1'b0;
          phase_nxt = (bit_cnt_r >= BYTE_BITS) ? PH_R_ACK : PH_R_HI;
        end
        PH_R_ACK: begin
          // Acknowledge data bytes, leave the CRC byte unacknowledged
          dat_nxt   = (byte_idx_r < 2'd2) ? 1'b0 : 1'b1;
          phase_nxt = PH_R_AHI;
        end
        PH_R_AHI: begin
          clk_nxt   = 1'b1;
          phase_nxt = PH_R_ALO;
        end
        PH_R_ALO: begin
          clk_nxt   = 1'b0;
          phase_nxt = PH_R_END;
        end
        PH_R_END: begin
          dat_nxt = 1'b1;
          if (byte_idx_r == 2'd0) begin
            word_nxt     = {shift_r, 8'd0};
            byte_idx_nxt = 2'd1;
            phase_nxt    = PH_R_REL;
          end else if (byte_idx_r == 2'd1) begin
            word_nxt     = {word_r[15:8], shift_r};
            byte_idx_nxt = 2'd2;
            phase_nxt    = PH_R_REL;
          end else begin
            op_nxt    = OP_IDLE;
            phase_nxt = PH_RST_HI;
            fin_done  = 1'b1;
            fin_raw   = word_r;
          end
        end
        default: begin
          op_nxt    = OP_IDLE;
          phase_nxt = PH_RST_HI;
        end
      endcase
    end
  end

  // State advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= OP_IDLE;
      phase_r    <= PH_RST_HI;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      word_r     <= 16'd0;
      byte_idx_r <= 2'd0;
      clk_r      <= 1'b0;
      dat_r      <= 1'b1;
      wait_cnt_r <= '0;
    end else if (step) begin
      op_r       <= op_nxt;
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      word_r     <= word_nxt;
      byte_idx_r <= byte_idx_nxt;
      clk_r      <= clk_nxt;
      dat_r      <= dat_nxt;
      wait_cnt_r <= wait_cnt_nxt;
    end
  end

  always_comb begin
    res.clock_level  = clk_nxt;
    res.data_release = dat_nxt;
    res.busy_res     = (op_nxt != OP_IDLE);
    res.done_res     = fin_done;
    res.timed_out    = fin_timeout;
    res.raw_value    = fin_raw;
  end

endmodule

/* rtl/tsbm_out_reg.sv */
// Result register: holds one result item, refills while the sink takes the old one.
`timescale 1ns / 1ps

module tsbm_out_reg
  import tsbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  result_t   res,
  output logic      can_load,
  tsbm_out_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.clock_level  = res_r.clock_level;
  assign out_ch.data_release = res_r.data_release;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.timed_out    = res_r.timed_out;
  assign out_ch.raw_value    = res_r.raw_value;

endmodule

/* rtl/two_wire_sensor_bus_master_core.sv */
// Top level of the two-wire sensor bus master.
//
// Usage: every item on in_ch is one half-bit tick from a prescaler, carrying the
// sampled data line and a request code (reset, status write, temperature or
// humidity measurement); the request is taken only when no operation runs.
// Every accepted item yields exactly one result item on out_ch: the clock level
// and data release to drive on the pins, busy, a one-item done pulse, the
// timeout flag and the raw 16-bit measurement on the finishing item.
// Configuration (command bytes, status byte, poll limit) is written through
// cfg_wr_en / cfg_index / cfg_data while the block is idle.
// The result is registered: it appears on out_ch in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ch does not stall; the sequencer state
// updates on each accepted item and the result register takes a new result in the
// same cycle the sink takes the old one.
// Reset (rst_n low, synchronous): sequencer idle, clock low, data released,
// configuration at its defaults, result register empty.
// When out_ch stalls, the held result stays and in_ch.ready drops until it is
// taken.
`timescale 1ns / 1ps

module two_wire_sensor_bus_master_core
  import tsbm_pkg::*;
#(
  parameter int unsigned WAIT_COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tsbm_in_if.sink               in_ch,
  tsbm_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    can_load;
  logic    accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  tsbm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tsbm_seq #(
    .WAIT_COUNT_BITS (WAIT_COUNT_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .cmd   (in_ch.cmd),
    .line  (in_ch.data_line),
    .cfg   (cfg),
    .res   (res)
  );

  tsbm_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

/* rtl/tsbm_checker.sv */
// Port-level checker for the sensor bus master, bound to the top level.
`timescale 1ns / 1ps

module tsbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        busy_res,
  input logic        done_res,
  input logic        timed_out,
  input logic [15:0] raw_value
);

  // Result register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A finishing item leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> !busy_res)
    else $error("done with busy still set");

  // Timeout only on a finishing item, and with a zero value
  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && timed_out) |-> (done_res && raw_value == 16'd0))
    else $error("timeout flag without done or with a value");

  // A value is only reported on a finishing item
  a_raw_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && raw_value != 16'd0) |-> done_res)
    else $error("raw value outside a finishing item");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(raw_value) && $stable(done_res)))
    else $error("stalled result changed");

endmodule

bind two_wire_sensor_bus_master_core tsbm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .timed_out (out_ch.timed_out),
  .raw_value (out_ch.raw_value)
);

/* dv/tsbm_bus_checker.sv */
// Checker: predicts the pin levels and flags of every accepted tick and compares the block's results.
`timescale 1ns / 1ps

module tsbm_bus_checker
  import tsbm_pkg::*;
#(
  parameter int unsigned WAIT_COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tsbm_in_if                    in_mon,
  tsbm_out_if                   out_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // Shadow configuration and sequencer state
  cfg_t                       regs;
  logic [2:0]                 op;
  logic [4:0]                 ph;
  logic [3:0]                 nbits;
  logic [7:0]                 shreg;
  logic [15:0]                word;
  logic [WAIT_COUNT_BITS-1:0] polls;
  logic                       scl;
  logic                       sda;
  logic [1:0]                 byte_no;

  // Flags of the tick being predicted
  logic                       end_flag;
  logic                       end_expired;
  logic [15:0]                end_raw;

  result_t predicted_pins[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic close_op(input bit measured, input bit expired);
    op          = OP_IDLE;
    ph          = PH_RST_HI;
    end_flag    = 1'b1;
    end_expired = expired;
    end_raw     = (measured && !expired) ? word : 16'h0000;
  endtask

  task automatic load_byte(input logic [7:0] value);
    shreg = value;
    nbits = '0;
    ph    = PH_W_LO;
  endtask

  // One half-bit tick of the bus sequencer
  task automatic step_bus(input logic [2:0] req, input logic line, output result_t r);
    end_flag    = 1'b0;
    end_expired = 1'b0;
    end_raw     = 16'h0000;
    if (op == OP_IDLE) begin
      if (req == OP_RESET) begin
        op    = OP_RESET;
        sda   = 1'b1;
        nbits = '0;
        ph    = PH_RST_HI;
      end else if (req == OP_STATUS || req == OP_TEMP || req == OP_HUMI) begin
        op  = req;
        scl = 1'b1;
        ph  = PH_S1;
      end
    end else begin
      case (ph)
        PH_RST_HI: begin
          scl = 1'b1;
          ph  = PH_RST_LO;
        end
        PH_RST_LO: begin
          scl   = 1'b0;
          nbits = nbits + 1'b1;
          if (nbits >= RESET_PULSES) close_op(1'b0, 1'b0);
          else ph = PH_RST_HI;
        end
        PH_S1: begin sda = 1'b0; ph = PH_S2; end
        PH_S2: begin scl = 1'b0; ph = PH_S3; end
        PH_S3: begin scl = 1'b1; ph = PH_S4; end
        PH_S4: begin sda = 1'b1; ph = PH_S5; end
        PH_S5: begin
          scl     = 1'b0;
          byte_no = '0;
          case (op)
            OP_STATUS: load_byte(regs.status_write_command);
            OP_TEMP:   load_byte(regs.temperature_command);
            default:   load_byte(regs.humidity_command);
          endcase
        end
        // byte write, MSB first
        PH_W_LO:  begin scl = 1'b0; ph = PH_W_DAT; end
        PH_W_DAT: begin sda = shreg[7]; ph = PH_W_HI; end
        PH_W_HI: begin
          scl   = 1'b1;
          shreg = {shreg[6:0], 1'b0};
          nbits = nbits + 1'b1;
          ph    = (nbits >= BYTE_BITS) ? PH_W_T0 : PH_W_LO;
        end
        // acknowledge slot, not checked
        PH_W_T0: begin scl = 1'b0; ph = PH_W_T1; end
        PH_W_T1: begin sda = 1'b1; ph = PH_W_T2; end
        PH_W_T2: begin scl = 1'b1; ph = PH_W_T3; end
        PH_W_T3: begin scl = 1'b0; ph = PH_W_T4; end
        PH_W_T4: begin
          sda = 1'b1;
          if (op == OP_STATUS) begin
            if (byte_no == 2'd0) begin
              byte_no = 2'd1;
              load_byte(regs.status_value);
            end else begin
              close_op(1'b0, 1'b0);
            end
          end else begin
            polls = '0;
            ph    = PH_POLL;
          end
        end
        // wait for the sensor to pull data low; counter saturates at its top
        PH_POLL: begin
          if (!line) begin
            byte_no = '0;
            nbits   = '0;
            ph      = PH_R_REL;
          end else if (polls >= regs.wait_limit || polls == '1) begin
            word = 16'h0000;
            close_op(1'b1, 1'b1);
          end else begin
            polls = polls + 1'b1;
          end
        end
        // byte read
        PH_R_REL: begin
          sda   = 1'b1;
          shreg = '0;
          nbits = '0;
          ph    = PH_R_HI;
        end
        PH_R_HI: begin scl = 1'b1; ph = PH_R_SMP; end
        PH_R_SMP: begin
          shreg = {shreg[6:0], line};
          nbits = nbits + 1'b1;
          ph    = PH_R_LO;
        end
        PH_R_LO: begin
          scl = 1'b0;
          ph  = (nbits >= BYTE_BITS) ? PH_R_ACK : PH_R_HI;
        end
        // acknowledge MSB and LSB, leave the CRC byte unacknowledged
        PH_R_ACK: begin sda = (byte_no < 2'd2) ? 1'b0 : 1'b1; ph = PH_R_AHI; end
        PH_R_AHI: begin scl = 1'b1; ph = PH_R_ALO; end
        PH_R_ALO: begin scl = 1'b0; ph = PH_R_END; end
        PH_R_END: begin
          sda = 1'b1;
          if (byte_no == 2'd0) begin
            word    = {shreg, 8'h00};
            byte_no = 2'd1;
            ph      = PH_R_REL;
          end else if (byte_no == 2'd1) begin
            word[7:0] = shreg;
            byte_no   = 2'd2;
            ph        = PH_R_REL;
          end else begin
            close_op(1'b1, 1'b0);
          end
        end
        default: begin
          op = OP_IDLE;
          ph = PH_RST_HI;
        end
      endcase
    end
    r.clock_level  = scl;
    r.data_release = sda;
    r.busy_res     = (op != OP_IDLE);
    r.done_res     = end_flag;
    r.timed_out    = end_expired;
    r.raw_value    = end_raw;
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Follow configuration writes, compare results, then predict the new tick
  always @(posedge clk) begin : track
    result_t seen;
    result_t want;
    result_t next;
    if (!rst_n) begin
      regs.status_write_command = RST_STATUS_CMD;
      regs.status_value         = RST_STATUS_VAL;
      regs.temperature_command  = RST_TEMP_CMD;
      regs.humidity_command     = RST_HUMI_CMD;
      regs.wait_limit           = RST_WAIT_LIMIT;
      op      = OP_IDLE;
      ph      = PH_RST_HI;
      nbits   = '0;
      shreg   = '0;
      word    = '0;
      polls   = '0;
      scl     = 1'b0;
      sda     = 1'b1;
      byte_no = '0;
      predicted_pins.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_STATUS_CMD: regs.status_write_command = cfg_data[7:0];
          CFG_STATUS_VAL: regs.status_value         = cfg_data[7:0];
          CFG_TEMP_CMD:   regs.temperature_command  = cfg_data[7:0];
          CFG_HUMI_CMD:   regs.humidity_command     = cfg_data[7:0];
          CFG_WAIT_LIMIT: regs.wait_limit           = cfg_data[23:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        seen.clock_level  = out_mon.clock_level;
        seen.data_release = out_mon.data_release;
        seen.busy_res     = out_mon.busy_res;
        seen.done_res     = out_mon.done_res;
        seen.timed_out    = out_mon.timed_out;
        seen.raw_value    = out_mon.raw_value;
        if (predicted_pins.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing actual %0h",
                   $time, seen);
          fail_count++;
        end else begin
          want = predicted_pins.pop_front();
          check_field("clock_level", 16'(want.clock_level), 16'(seen.clock_level));
          check_field("data_release", 16'(want.data_release), 16'(seen.data_release));
          check_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
          check_field("done_res", 16'(want.done_res), 16'(seen.done_res));
          check_field("timed_out", 16'(want.timed_out), 16'(seen.timed_out));
          check_field("raw_value", want.raw_value, seen.raw_value);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        step_bus(in_mon.cmd, in_mon.data_line, next);
        predicted_pins.push_back(next);
      end
      pending <= predicted_pins.size();
    end
  end

endmodule

/* dv/two_wire_sensor_bus_master_core_tb.sv */
// Testbench top: drives bus ticks and configuration into the sensor bus master and gives the verdict.
`timescale 1ns / 1ps

module two_wire_sensor_bus_master_core_tb;
  import tsbm_pkg::*;

  localparam int unsigned WAIT_COUNT_BITS = 24;
  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_OPS   = 1;
  localparam int START_TICKS  = 5;   // start sequence after the request tick
  localparam int WRITE_TICKS  = 29;  // 8 bits of 3 ticks plus 5 for the ack slot
  localparam int READ_TICKS   = 29;  // release, 8 bits of 3 ticks, 4 for the ack
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  bit                    calm = 1'b0;
  int                    quiet_cycles = 0;
  int                    stall_left = 0;
  int unsigned           limit_now;

  tsbm_in_if  in_ch ();
  tsbm_out_if out_ch ();

  always #10 clk = ~clk;

  two_wire_sensor_bus_master_core #(
    .WAIT_COUNT_BITS(WAIT_COUNT_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsbm_bus_checker #(
    .WAIT_COUNT_BITS(WAIT_COUNT_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side back-pressure: mostly ready, short stalls, the odd long one
  always @(negedge clk) begin : sink_stall
    int r;
    r = $urandom_range(0, 99);
    if (calm) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (r < 70) begin
      out_ch.ready <= 1'b1;
    end else if (r < 95) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(8, 40);
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("two_wire_sensor_bus_master_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Request field while an operation runs: mostly none, sometimes anything
  function automatic logic [2:0] busy_cmd();
    if ($urandom_range(0, 3) != 0) return OP_IDLE;
    return 3'($urandom_range(OP_IDLE, REQ_UNUSED_LAST));
  endfunction

  // Request field between operations that starts nothing
  function automatic logic [2:0] idle_cmd();
    if ($urandom_range(0, 1) == 0) return OP_IDLE;
    return 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
  endfunction

  task automatic send_tick(input logic [2:0] req, input logic line);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= req;
    in_ch.data_line <= line;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_reset();
    send_tick(OP_RESET, coin());
    repeat (2 * RESET_PULSES) send_tick(busy_cmd(), coin());
  endtask

  task automatic run_status();
    send_tick(OP_STATUS, coin());
    repeat (START_TICKS + 2 * WRITE_TICKS) send_tick(busy_cmd(), coin());
  endtask

  // Measurement as the sensor would answer: hold data high for a while, pull it
  // low, then present MSB, LSB and a CRC byte on the sample ticks; with expire it stays high
  task automatic run_measure(input logic [2:0] kind, input int unsigned delay,
                             input bit expire, input logic [15:0] value);
    logic [7:0] frame [3];
    int         k;
    frame[0] = value[15:8];
    frame[1] = value[7:0];
    frame[2] = 8'($urandom_range(0, 255));
    send_tick(kind, coin());
    repeat (START_TICKS + WRITE_TICKS) send_tick(busy_cmd(), coin());
    if (expire) begin
      repeat (limit_now + 1) send_tick(busy_cmd(), 1'b1);
    end else begin
      repeat (delay) send_tick(busy_cmd(), 1'b1);
      send_tick(busy_cmd(), 1'b0);
      foreach (frame[j]) begin
        for (k = 0; k < READ_TICKS; k++) begin
          if (k >= 2 && k < 2 + 3 * BYTE_BITS && (k - 2) % 3 == 0)
            send_tick(busy_cmd(), frame[j][7 - (k - 2) / 3]);
          else
            send_tick(busy_cmd(), coin());
        end
      end
    end
  endtask

  task automatic run_random_op();
    int          r;
    bit          expire;
    int unsigned delay;
    logic [15:0] value;
    repeat ($urandom_range(0, 3)) send_tick(idle_cmd(), coin());
    r = $urandom_range(0, 9);
    if (r == 0) begin
      run_reset();
    end else if (r < 3) begin
      run_status();
    end else begin
      expire = (limit_now <= 64) && ($urandom_range(0, 4) == 0);
      delay  = $urandom_range(0, (limit_now < 12) ? limit_now : 12);
      case ($urandom_range(0, 9))
        0:       value = 16'h0000;
        1:       value = 16'hFFFF;
        default: value = 16'($urandom_range(0, 16'hFFFF));
      endcase
      run_measure((r < 6) ? OP_TEMP : OP_HUMI, delay, expire, value);
    end
  endtask

  // Let every outstanding result drain with the input channel quiet
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_WAIT_LIMIT) limit_now = 32'(value);
  endtask

  task automatic set_config(input logic [7:0] status_cmd, input logic [7:0] status_val,
                            input logic [7:0] temp_cmd, input logic [7:0] humi_cmd,
                            input logic [23:0] wait_lim, input bit poke_spare);
    drain();
    repeat (2) @(negedge clk);
    write_reg(CFG_STATUS_CMD, 24'(status_cmd));
    write_reg(CFG_STATUS_VAL, 24'(status_val));
    write_reg(CFG_TEMP_CMD, 24'(temp_cmd));
    write_reg(CFG_HUMI_CMD, 24'(humi_cmd));
    write_reg(CFG_WAIT_LIMIT, wait_lim);
    if (poke_spare) write_reg(CFG_SPARE, 24'($urandom_range(0, 24'hFFFFFF)));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = OP_IDLE;
    in_ch.data_line = 1'b1;
    out_ch.ready    = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_STATUS_CMD;
    cfg_data        = '0;
    limit_now       = 32'(RST_WAIT_LIMIT);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: requests that start nothing, reset, status and temperature, a full-scale value
    send_tick(OP_IDLE, 1'b0);
    for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++) send_tick(3'(c), coin());
    run_reset();
    run_status();
    run_measure(OP_TEMP, 0, 1'b0, 16'hFFFF);

    // Lowest command bytes, poll limit of 1: a timeout with no idling on either side
    set_config(8'h00, 8'h00, 8'h00, 8'h00, 24'd1, 1'b1);
    calm = 1'b1;
    run_measure(OP_HUMI, 0, 1'b1, 16'h0000);
    calm = 1'b0;

    // Highest settings, no back-pressure or gaps
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0);
    calm = 1'b1;
    repeat (RANDOM_OPS) run_random_op();
    calm = 1'b0;

    // Random settings with a short poll limit so that timeouts can occur
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               24'($urandom_range(1, 30)), 1'b0);
    repeat (RANDOM_OPS) run_random_op();

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("two_wire_sensor_bus_master_core regression: pass");
    end else begin
      $display("two_wire_sensor_bus_master_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tsbm_pkg.sv
rtl/tsbm_if.sv
rtl/tsbm_cfg.sv
rtl/tsbm_seq.sv
rtl/tsbm_out_reg.sv
rtl/two_wire_sensor_bus_master_core.sv
rtl/tsbm_checker.sv
dv/tsbm_bus_checker.sv
dv/two_wire_sensor_bus_master_core_tb.sv
